[rtl/assert_macros.svh]
// Assertion macros used by the top level of the playback resampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define ARPR_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, held off during reset.
`define ARPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/arpr_pkg.sv]
// Types and constants of the ring playback resampler.
package arpr_pkg;

    // Input op codes
    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_TICK  = 3'd1;
    localparam logic [2:0] OP_PLAY  = 3'd2;
    localparam logic [2:0] OP_STOP  = 3'd3;
    localparam logic [2:0] OP_END   = 3'd4;

    // Sample formats
    localparam logic [1:0] FMT_8_MONO    = 2'd0;
    localparam logic [1:0] FMT_8_STEREO  = 2'd1;
    localparam logic [1:0] FMT_16_MONO   = 2'd2;
    localparam logic [1:0] FMT_16_STEREO = 2'd3;

    // Register map
    localparam int          ADDR_W     = 4;
    localparam logic [1:0]  REG_FORMAT = 2'd0;
    localparam logic [1:0]  REG_STEP   = 2'd1;
    localparam logic [1:0]  REG_VOLUME = 2'd2;
    localparam logic [1:0]  REG_PAN    = 2'd3;

    localparam logic [1:0]  RST_FORMAT = FMT_16_STEREO;
    localparam logic [17:0] RST_STEP   = 18'd65536;
    localparam logic [15:0] RST_VOLUME = 16'd32768;
    localparam logic [8:0]  RST_PAN    = 9'd0;

    localparam int GUARD_FRAMES = 16;
    localparam int PAN_UNITY    = 128;
    localparam int SCALE_SHIFT  = 14;
    localparam int OUT_W        = 25;

    // Command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    typedef enum logic [2:0] {
        CMD_WRITE,
        CMD_TICK,
        CMD_PLAY,
        CMD_STOP,
        CMD_END,
        CMD_NONE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] frame;   // right in [31:16], left in [15:0]
    } cmd_t;

    typedef struct packed {
        logic        full;
        logic        empty;
    } q_stat_t;

    typedef struct packed {
        logic [1:0]        sample_format;
        logic [17:0]       rate_step;
        logic [15:0]       volume_gain;
        logic signed [8:0] pan_position;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_FIN
    } state_t;

endpackage

[rtl/audio_ring_playback_resampler_top.sv]
// Top level of the ring playback resampler: registers, front, queue and back.
//
// Use: write stereo or mono frames into the ring with op write, start playback
// with op play, and issue one op tick per output frame. Each input beat on
// in_valid/in_ready gives exactly one result beat on out_valid/out_ready with
// the scaled samples (ticks only), the playing flag, free space, refill request
// and the dropped-write flag. Format, step, volume and pan are set over the APB
// port; the user must set them only while no item is in flight, as the block
// itself does not enforce it. A tick that reads the ring passes the ring read,
// volume multiply and pan multiply registers before the result register; other
// items go straight to the result register. The back executes one item at a
// time and takes no new item until its result is loaded; the front and a
// two-entry queue keep taking beats meanwhile.
// Reset puts the positions at zero, clears playing and end-of-stream and loads
// the default configuration; ring contents are undefined until written and no
// clearing pass runs. When the receiver stalls, the result holds in the output
// register, the back waits, the queue fills and in_ready drops.
module audio_ring_playback_resampler_top
#(
    parameter  int RING_DEPTH = 8192,
    localparam int FW         = $clog2(RING_DEPTH + 1)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [arpr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  op,
    input  logic signed [15:0]          sample_left,
    input  logic signed [15:0]          sample_right,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [24:0]          left_out,
    output logic signed [24:0]          right_out,
    output logic                        playing_out,
    output logic [FW-1:0]               free_frames,
    output logic                        refill_wanted,
    output logic                        overflow
);

`include "assert_macros.svh"

    localparam logic [FW-1:0] FREE_MAX = FW'(RING_DEPTH - arpr_pkg::GUARD_FRAMES);

    arpr_pkg::cfg_t    cfg;
    arpr_pkg::cmd_t    push_cmd;
    arpr_pkg::cmd_t    head_cmd;
    arpr_pkg::q_stat_t q_stat;
    logic              push;
    logic              pop;
    logic              out_silent;

    assign out_silent = (left_out == '0) && (right_out == '0);

    arpr_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    arpr_front u_front
    (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .sample_left   (sample_left),
        .sample_right  (sample_right),
        .sample_format (cfg.sample_format),
        .q_stat        (q_stat),
        .push          (push),
        .cmd           (push_cmd)
    );

    arpr_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    arpr_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (head_cmd),
        .cmd_valid     (!q_stat.empty),
        .cmd_pop       (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .left_out      (left_out),
        .right_out     (right_out),
        .playing_out   (playing_out),
        .free_frames   (free_frames),
        .refill_wanted (refill_wanted),
        .overflow      (overflow)
    );

    `ARPR_ASSERT_NEXT(a_push_lands, push, !q_stat.empty, "accepted beat missing from queue")
    `ARPR_ASSERT_IMPLY(a_drop_silent, out_valid && overflow, out_silent, "dropped write has samples")
    `ARPR_ASSERT_IMPLY(a_free_bound, out_valid, free_frames <= FREE_MAX, "free count too large")

endmodule

[rtl/arpr_regs.sv]
// APB configuration registers of the playback resampler.
module arpr_regs
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [arpr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output arpr_pkg::cfg_t            cfg
);

    arpr_pkg::cfg_t cfg_reg;
    arpr_pkg::cfg_t cfg_next;
    logic [1:0]     reg_index;
    logic           wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                arpr_pkg::REG_FORMAT: cfg_next.sample_format = pwdata[1:0];
                arpr_pkg::REG_STEP:   cfg_next.rate_step     = pwdata[17:0];
                arpr_pkg::REG_VOLUME: cfg_next.volume_gain   = pwdata[15:0];
                arpr_pkg::REG_PAN:    cfg_next.pan_position  = $signed(pwdata[8:0]);
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            arpr_pkg::REG_FORMAT: prdata = {30'd0, cfg_reg.sample_format};
            arpr_pkg::REG_STEP:   prdata = {14'd0, cfg_reg.rate_step};
            arpr_pkg::REG_VOLUME: prdata = {16'd0, cfg_reg.volume_gain};
            arpr_pkg::REG_PAN:    prdata = {{23{cfg_reg.pan_position[8]}},
                                            cfg_reg.pan_position};
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_format <= arpr_pkg::RST_FORMAT;
            cfg_reg.rate_step     <= arpr_pkg::RST_STEP;
            cfg_reg.volume_gain   <= arpr_pkg::RST_VOLUME;
            cfg_reg.pan_position  <= $signed(arpr_pkg::RST_PAN);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/arpr_front.sv]
// Input side: accept beats, decode the op and format the frame for the queue.
module arpr_front
(
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         op,
    input  logic signed [15:0] sample_left,
    input  logic signed [15:0] sample_right,
    input  logic [1:0]         sample_format,
    input  arpr_pkg::q_stat_t  q_stat,
    output logic               push,
    output arpr_pkg::cmd_t     cmd
);

    logic [15:0] left_ext;
    logic [15:0] right_ext;
    logic [15:0] right_sel;

    assign in_ready = !q_stat.full;
    assign push     = in_valid && in_ready;

    // 8-bit formats take the low byte, sign-extended
    always_comb
    begin
        case (sample_format) inside
            arpr_pkg::FMT_8_MONO, arpr_pkg::FMT_8_STEREO:
            begin
                left_ext  = {{8{sample_left[7]}}, sample_left[7:0]};
                right_ext = {{8{sample_right[7]}}, sample_right[7:0]};
            end
            default:
            begin
                left_ext  = sample_left;
                right_ext = sample_right;
            end
        endcase
    end

    // Mono formats copy left into right
    always_comb
    begin
        case (sample_format) inside
            arpr_pkg::FMT_8_MONO, arpr_pkg::FMT_16_MONO: right_sel = left_ext;
            default:                                     right_sel = right_ext;
        endcase
    end

    always_comb
    begin
        cmd.frame = {right_sel, left_ext};
        unique case (op)
            arpr_pkg::OP_WRITE: cmd.kind = arpr_pkg::CMD_WRITE;
            arpr_pkg::OP_TICK:  cmd.kind = arpr_pkg::CMD_TICK;
            arpr_pkg::OP_PLAY:  cmd.kind = arpr_pkg::CMD_PLAY;
            arpr_pkg::OP_STOP:  cmd.kind = arpr_pkg::CMD_STOP;
            arpr_pkg::OP_END:   cmd.kind = arpr_pkg::CMD_END;
            default:            cmd.kind = arpr_pkg::CMD_NONE;
        endcase
    end

endmodule

[rtl/arpr_queue.sv]
// Two-entry command queue between the front and back halves.
module arpr_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  arpr_pkg::cmd_t    push_cmd,
    input  logic              pop,
    output arpr_pkg::cmd_t    head_cmd,
    output arpr_pkg::q_stat_t q_stat
);

    arpr_pkg::cmd_t              entry_reg [arpr_pkg::Q_DEPTH];
    logic [arpr_pkg::Q_AW-1:0]   wr_ptr_reg;
    logic [arpr_pkg::Q_AW-1:0]   wr_ptr_next;
    logic [arpr_pkg::Q_AW-1:0]   rd_ptr_reg;
    logic [arpr_pkg::Q_AW-1:0]   rd_ptr_next;
    logic [arpr_pkg::Q_AW:0]     count_reg;
    logic [arpr_pkg::Q_AW:0]     count_next;

    assign head_cmd     = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == (arpr_pkg::Q_AW+1)'(arpr_pkg::Q_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/arpr_back.sv]
// Execution side: frame ring, play position, gain scaling and result register.
module arpr_back
#(
    parameter  int RING_DEPTH = 8192,
    localparam int AW         = $clog2(RING_DEPTH),
    localparam int FW         = $clog2(RING_DEPTH + 1),
    localparam int PW         = AW + 17
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  arpr_pkg::cfg_t      cfg,
    input  arpr_pkg::cmd_t      cmd,
    input  logic                cmd_valid,
    output logic                cmd_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [24:0]  left_out,
    output logic signed [24:0]  right_out,
    output logic                playing_out,
    output logic [FW-1:0]       free_frames,
    output logic                refill_wanted,
    output logic                overflow
);

    localparam logic [FW-1:0] DEPTH_F  = FW'(RING_DEPTH);
    localparam logic [FW-1:0] GUARD_F  = FW'(arpr_pkg::GUARD_FRAMES);
    localparam logic [FW-1:0] REFILL_F = FW'(RING_DEPTH / 5);
    localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);
    localparam logic [PW-1:0] END_FIX  = {(AW + 1)'(RING_DEPTH), 16'd0};

    logic [31:0] ring_mem [RING_DEPTH];
    logic [31:0] rdata_reg;

    arpr_pkg::state_t state_reg;
    arpr_pkg::state_t state_next;

    logic [AW-1:0] wr_pos_reg;
    logic [AW-1:0] wr_pos_next;
    logic [AW-1:0] rd_int_reg;
    logic [AW-1:0] rd_int_next;
    logic [15:0]   rd_frac_reg;
    logic [15:0]   rd_frac_next;
    logic          playing_reg;
    logic          playing_next;
    logic          ended_reg;
    logic          ended_next;
    logic          tick_reg;
    logic          tick_next;
    logic          ovf_reg;
    logic          ovf_next;

    logic          mem_we;
    logic          mem_re;
    logic          active;
    logic [PW-1:0] new_pos;
    logic [PW-1:0] wr_fix;

    logic [FW-1:0] raw_free;
    logic [FW-1:0] free_cnt;
    logic          ring_full;

    logic [7:0]          gain_left;
    logic [7:0]          gain_right;
    logic signed [32:0]  prod1_l_reg;
    logic signed [32:0]  prod1_r_reg;
    logic signed [41:0]  prod2_l_reg;
    logic signed [41:0]  prod2_r_reg;
    logic signed [41:0]  bias_l;
    logic signed [41:0]  bias_r;
    logic signed [41:0]  quot_l;
    logic signed [41:0]  quot_r;

    logic                out_load;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic signed [24:0]  left_reg;
    logic signed [24:0]  right_reg;
    logic                playing_out_reg;
    logic [FW-1:0]       free_reg;
    logic                refill_reg;
    logic                ovf_out_reg;

    function automatic logic [7:0] clamp_gain(input logic signed [9:0] g);
        logic [7:0] r;
        if (g < 0)
        begin
            r = 8'd0;
        end
        else if (g > 10'sd128)
        begin
            r = 8'(arpr_pkg::PAN_UNITY);
        end
        else
        begin
            r = g[7:0];
        end
        return r;
    endfunction

    // Free space from the current positions
    always_comb
    begin
        if (rd_int_reg == wr_pos_reg)
        begin
            raw_free = DEPTH_F;
        end
        else if (rd_int_reg < wr_pos_reg)
        begin
            raw_free = DEPTH_F - FW'(wr_pos_reg) + FW'(rd_int_reg);
        end
        else
        begin
            raw_free = FW'(rd_int_reg) - FW'(wr_pos_reg);
        end
    end

    assign free_cnt  = (raw_free > GUARD_F) ? (raw_free - GUARD_F) : '0;
    assign ring_full = (raw_free <= FW'(1));

    assign gain_left  = clamp_gain(10'sd128 - 10'(cfg.pan_position));
    assign gain_right = clamp_gain(10'sd128 + 10'(cfg.pan_position));

    assign active = playing_reg && (cfg.rate_step != '0) && (cfg.volume_gain != '0);
    assign wr_fix = {1'b0, wr_pos_reg, 16'd0};

    assign cmd_pop  = (state_reg == arpr_pkg::ST_IDLE) && cmd_valid;
    assign out_load = (state_reg == arpr_pkg::ST_FIN) && (!out_valid_reg || out_ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            arpr_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = mem_re ? arpr_pkg::ST_MUL1 : arpr_pkg::ST_FIN;
                end
            end
            arpr_pkg::ST_MUL1: state_next = arpr_pkg::ST_MUL2;
            arpr_pkg::ST_MUL2: state_next = arpr_pkg::ST_FIN;
            arpr_pkg::ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = arpr_pkg::ST_IDLE;
                end
            end
            default: state_next = arpr_pkg::ST_IDLE;
        endcase
    end

    // Command execution: ring and position updates
    always_comb
    begin
        wr_pos_next  = wr_pos_reg;
        rd_int_next  = rd_int_reg;
        rd_frac_next = rd_frac_reg;
        playing_next = playing_reg;
        ended_next   = ended_reg;
        tick_next    = tick_reg;
        ovf_next     = ovf_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        new_pos      = {1'b0, rd_int_reg, rd_frac_reg} + PW'(cfg.rate_step);

        if (cmd_pop)
        begin
            tick_next = 1'b0;
            ovf_next  = 1'b0;
            case (cmd.kind)
                arpr_pkg::CMD_WRITE:
                begin
                    if (ring_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        mem_we      = 1'b1;
                        wr_pos_next = (wr_pos_reg == LAST_IDX) ? '0 : wr_pos_reg + 1'b1;
                    end
                end
                arpr_pkg::CMD_TICK:
                begin
                    if (active)
                    begin
                        if (rd_int_reg == wr_pos_reg)
                        begin
                            // underrun: hold position
                            if (ended_reg)
                            begin
                                playing_next = 1'b0;
                            end
                        end
                        else
                        begin
                            mem_re    = 1'b1;
                            tick_next = 1'b1;
                            // catch up to the writer
                            if ((rd_int_reg < wr_pos_reg) && (new_pos >= wr_fix))
                            begin
                                new_pos = wr_fix;
                                if (ended_reg)
                                begin
                                    playing_next = 1'b0;
                                end
                            end
                            // wrap at ring end
                            if (new_pos >= END_FIX)
                            begin
                                new_pos = new_pos - END_FIX;
                                if (new_pos >= wr_fix)
                                begin
                                    new_pos = wr_fix;
                                    if (ended_reg)
                                    begin
                                        playing_next = 1'b0;
                                    end
                                end
                            end
                            rd_int_next  = new_pos[AW+15:16];
                            rd_frac_next = new_pos[15:0];
                        end
                    end
                end
                arpr_pkg::CMD_PLAY: playing_next = 1'b1;
                arpr_pkg::CMD_STOP: playing_next = 1'b0;
                arpr_pkg::CMD_END:  ended_next   = 1'b1;
                default:            playing_next = playing_reg;
            endcase
        end
    end

    // Truncate toward zero on the divide by 2^14
    assign bias_l = prod2_l_reg + ((prod2_l_reg < 0) ? 42'sd16383 : 42'sd0);
    assign bias_r = prod2_r_reg + ((prod2_r_reg < 0) ? 42'sd16383 : 42'sd0);
    assign quot_l = bias_l >>> arpr_pkg::SCALE_SHIFT;
    assign quot_r = bias_r >>> arpr_pkg::SCALE_SHIFT;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[wr_pos_reg] <= cmd.frame;
        end
        if (mem_re)
        begin
            rdata_reg <= ring_mem[rd_int_reg];
        end
    end

    // Scaling pipeline: volume, then pan gain
    always_ff @(posedge clk)
    begin
        prod1_l_reg <= 33'($signed(rdata_reg[15:0]) * $signed({1'b0, cfg.volume_gain}));
        prod1_r_reg <= 33'($signed(rdata_reg[31:16]) * $signed({1'b0, cfg.volume_gain}));
        prod2_l_reg <= 42'(prod1_l_reg * $signed({1'b0, gain_left}));
        prod2_r_reg <= 42'(prod1_r_reg * $signed({1'b0, gain_right}));
        tick_reg    <= tick_next;
        ovf_reg     <= ovf_next;
        if (out_load)
        begin
            left_reg        <= tick_reg ? quot_l[24:0] : '0;
            right_reg       <= tick_reg ? quot_r[24:0] : '0;
            playing_out_reg <= playing_reg;
            free_reg        <= free_cnt;
            refill_reg      <= (free_cnt > REFILL_F);
            ovf_out_reg     <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= arpr_pkg::ST_IDLE;
            wr_pos_reg    <= '0;
            rd_int_reg    <= '0;
            rd_frac_reg   <= '0;
            playing_reg   <= 1'b0;
            ended_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_pos_reg    <= wr_pos_next;
            rd_int_reg    <= rd_int_next;
            rd_frac_reg   <= rd_frac_next;
            playing_reg   <= playing_next;
            ended_reg     <= ended_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign left_out      = left_reg;
    assign right_out     = right_reg;
    assign playing_out   = playing_out_reg;
    assign free_frames   = free_reg;
    assign refill_wanted = refill_reg;
    assign overflow      = ovf_out_reg;

endmodule

[verif/audio_ring_playback_resampler_top_tb.sv]
// Self-checking testbench for the ring playback resampler top level.
module audio_ring_playback_resampler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 8192;
    localparam int FREE_W      = $clog2(DEPTH + 1);
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [2:0]  code;
        logic [15:0] left;
        logic [15:0] right;
    } ring_cmd_t;

    typedef struct packed {
        logic signed [24:0] left;
        logic signed [24:0] right;
        logic               playing;
        logic [FREE_W-1:0]  free;
        logic               refill;
        logic               ovf;
    } play_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [arpr_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         op = arpr_pkg::OP_WRITE;
    logic signed [15:0] sample_left = '0;
    logic signed [15:0] sample_right = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [24:0] left_out;
    logic signed [24:0] right_out;
    logic               playing_out;
    logic [FREE_W-1:0]  free_frames;
    logic               refill_wanted;
    logic               overflow;

    // stimulus and expected results
    ring_cmd_t    cmd_feed[$];
    ring_cmd_t    next_cmd;
    play_result_t due_outputs[$];
    play_result_t head;

    int send_idle_pct = 30;
    int recv_idle_pct = 49;
    int bad_count = 0;
    int hold_cycles = 0;
    bit in_taken = 1'b0;
    bit out_fire = 1'b0;

    // predictor state and register copies
    logic [31:0]       ring_mem [DEPTH];
    longint unsigned   rd_pos = 0;
    int unsigned       wr_idx = 0;
    bit                playing = 1'b0;
    bit                stream_done = 1'b0;
    logic [1:0]        cfg_fmt = arpr_pkg::RST_FORMAT;
    logic [17:0]       cfg_step = arpr_pkg::RST_STEP;
    logic [15:0]       cfg_vol = arpr_pkg::RST_VOLUME;
    logic signed [8:0] cfg_pan = arpr_pkg::RST_PAN;

    audio_ring_playback_resampler_top #(.RING_DEPTH(DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .sample_left   (sample_left),
        .sample_right  (sample_right),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .left_out      (left_out),
        .right_out     (right_out),
        .playing_out   (playing_out),
        .free_frames   (free_frames),
        .refill_wanted (refill_wanted),
        .overflow      (overflow)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned ring_space();
        int unsigned rd;
        rd = 32'(rd_pos >> 16);
        if (rd == wr_idx)
            return DEPTH;
        if (rd < wr_idx)
            return DEPTH - wr_idx + rd;
        return rd - wr_idx;
    endfunction

    function automatic int pan_gain(int g);
        if (g < 0)
            return 0;
        if (g > arpr_pkg::PAN_UNITY)
            return arpr_pkg::PAN_UNITY;
        return g;
    endfunction

    // truncates toward zero, as integer division does
    function automatic longint scaled(int s, int gain);
        return (longint'(s) * longint'(cfg_vol) * longint'(gain))
               / (1 << arpr_pkg::SCALE_SHIFT);
    endfunction

    function automatic void play_engine_step(logic [2:0] code, logic [15:0] l_in,
                                             logic [15:0] r_in);
        play_result_t    res;
        int              l;
        int              r;
        int              sl;
        int              sr;
        int unsigned     cur;
        int unsigned     space;
        int unsigned     ff;
        longint unsigned nxt;
        longint unsigned wfix;
        longint unsigned ring_end;
        logic [31:0]     fr;
        res = '0;
        ring_end = 64'(DEPTH) << 16;
        case (code)
            arpr_pkg::OP_WRITE:
            begin
                if (cfg_fmt == arpr_pkg::FMT_8_MONO || cfg_fmt == arpr_pkg::FMT_8_STEREO)
                begin
                    l = $signed(l_in[7:0]);
                    r = $signed(r_in[7:0]);
                end
                else
                begin
                    l = $signed(l_in);
                    r = $signed(r_in);
                end
                if (!cfg_fmt[0])
                    r = l;
                // keep one slot open so a full ring never looks empty
                if (ring_space() <= 1)
                    res.ovf = 1'b1;
                else
                begin
                    ring_mem[wr_idx] = {r[15:0], l[15:0]};
                    wr_idx = (wr_idx + 1) % DEPTH;
                end
            end
            arpr_pkg::OP_TICK:
            begin
                if (playing && cfg_step != 0 && cfg_vol != 0)
                begin
                    cur = 32'(rd_pos >> 16);
                    wfix = 64'(wr_idx) << 16;
                    if (cur == wr_idx)
                    begin
                        if (stream_done)
                            playing = 1'b0;
                    end
                    else
                    begin
                        fr = ring_mem[cur];
                        sl = $signed(fr[15:0]);
                        sr = $signed(fr[31:16]);
                        nxt = rd_pos + cfg_step;
                        if (cur < wr_idx && nxt >= wfix)
                        begin
                            nxt = wfix;
                            if (stream_done)
                                playing = 1'b0;
                        end
                        if (nxt >= ring_end)
                        begin
                            nxt -= ring_end;
                            if (nxt >= wfix)
                            begin
                                nxt = wfix;
                                if (stream_done)
                                    playing = 1'b0;
                            end
                        end
                        rd_pos = nxt;
                        res.left = 25'(scaled(sl,
                            pan_gain(arpr_pkg::PAN_UNITY - int'(cfg_pan))));
                        res.right = 25'(scaled(sr,
                            pan_gain(arpr_pkg::PAN_UNITY + int'(cfg_pan))));
                    end
                end
            end
            arpr_pkg::OP_PLAY: playing = 1'b1;
            arpr_pkg::OP_STOP: playing = 1'b0;
            arpr_pkg::OP_END:  stream_done = 1'b1;
            default: ;
        endcase
        space = ring_space();
        ff = (space > arpr_pkg::GUARD_FRAMES) ? space - arpr_pkg::GUARD_FRAMES : 0;
        res.playing = playing;
        res.free = FREE_W'(ff);
        res.refill = (ff > DEPTH / 5);
        due_outputs.push_back(res);
    endfunction

    function automatic bit work_left();
        return cmd_feed.size() != 0 || in_valid || due_outputs.size() != 0;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t ERROR %s: expected %0d, got %0d", $time, name, want, got);
            bad_count++;
        end
    endtask

    // input beat: present at the falling edge, hold until taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (cmd_feed.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_cmd = cmd_feed.pop_front();
                in_valid <= 1'b1;
                op <= next_cmd.code;
                sample_left <= next_cmd.left;
                sample_right <= next_cmd.right;
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        in_taken = rst_n && in_valid && in_ready;
        out_fire = rst_n && out_valid && out_ready;
        if (in_taken)
            play_engine_step(op, sample_left, sample_right);
        if (out_fire)
        begin
            if (due_outputs.size() == 0)
            begin
                $display("%0t ERROR result beat with none expected: left %0d right %0d",
                         $time, left_out, right_out);
                bad_count++;
            end
            else
            begin
                head = due_outputs.pop_front();
                check_field("left_out", head.left, left_out);
                check_field("right_out", head.right, right_out);
                check_field("playing_out", head.playing, playing_out);
                check_field("free_frames", head.free, free_frames);
                check_field("refill_wanted", head.refill, refill_wanted);
                check_field("overflow", head.ovf, overflow);
            end
        end
        if (in_taken || out_fire || !work_left())
            hold_cycles = 0;
        else
            hold_cycles++;
        if (hold_cycles >= STALL_LIMIT)
        begin
            $display("%0t ERROR no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void push_cmd(logic [2:0] code, logic [15:0] l, logic [15:0] r);
        ring_cmd_t c;
        c.code = code;
        c.left = l;
        c.right = r;
        cmd_feed.push_back(c);
    endfunction

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        case (idx)
            arpr_pkg::REG_FORMAT: cfg_fmt = value[1:0];
            arpr_pkg::REG_STEP:   cfg_step = value[17:0];
            arpr_pkg::REG_VOLUME: cfg_vol = value[15:0];
            arpr_pkg::REG_PAN:    cfg_pan = value[8:0];
            default: ;
        endcase
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic settle();
        do
            @(posedge clk);
        while (work_left());
    endtask

    task automatic rand_config();
        reg_write(arpr_pkg::REG_FORMAT, $urandom_range(3));
        if ($urandom_range(2) == 0)
            reg_write(arpr_pkg::REG_STEP, $urandom_range(16384, 131072));
        else
            reg_write(arpr_pkg::REG_STEP, $urandom_range(1, 262143));
        reg_write(arpr_pkg::REG_VOLUME, $urandom_range(1, 65535));
        reg_write(arpr_pkg::REG_PAN, $urandom_range(256) - 128);
    endtask

    // mostly write bursts followed by ticks, with control ops and noise between
    task automatic add_random(int count, bit with_end);
        int         made;
        int         pick;
        int         n;
        logic [2:0] code;
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                n = $urandom_range(1, 24);
                repeat (n) push_cmd(arpr_pkg::OP_WRITE, 16'($urandom), 16'($urandom));
                made += n;
                if ($urandom_range(3) == 0)
                begin
                    push_cmd(arpr_pkg::OP_PLAY, 16'($urandom), 16'($urandom));
                    made++;
                end
                n = $urandom_range(1, n + 4);
                repeat (n) push_cmd(arpr_pkg::OP_TICK, 16'($urandom), 16'($urandom));
                made += n;
            end
            else if (pick < 62)
            begin
                push_cmd(arpr_pkg::OP_PLAY, 16'($urandom), 16'($urandom));
                made++;
            end
            else if (pick < 68)
            begin
                push_cmd(arpr_pkg::OP_STOP, 16'($urandom), 16'($urandom));
                made++;
            end
            else if (pick < 76)
            begin
                code = 3'($urandom_range(7));
                if (code == arpr_pkg::OP_END && !with_end)
                    code = arpr_pkg::OP_TICK;
                push_cmd(code, 16'($urandom), 16'($urandom));
                made++;
            end
            else
            begin
                n = $urandom_range(1, 8);
                repeat (n) push_cmd(arpr_pkg::OP_TICK, 16'($urandom), 16'($urandom));
                made += n;
            end
        end
    endtask

    initial
    begin
        int pending;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // silent tick, sample extremes, unknown ops, underrun, stop
        push_cmd(arpr_pkg::OP_TICK, 16'h0000, 16'h0000);
        push_cmd(arpr_pkg::OP_WRITE, 16'h7FFF, 16'h8000);
        push_cmd(arpr_pkg::OP_WRITE, 16'h8000, 16'h7FFF);
        push_cmd(arpr_pkg::OP_WRITE, 16'hFFFF, 16'h0001);
        push_cmd(3'd5, 16'h5A5A, 16'hA5A5);
        push_cmd(3'd7, 16'hFFFF, 16'hFFFF);
        push_cmd(arpr_pkg::OP_PLAY, 16'h0000, 16'h0000);
        repeat (4) push_cmd(arpr_pkg::OP_TICK, 16'h0000, 16'h0000);
        push_cmd(arpr_pkg::OP_STOP, 16'h0000, 16'h0000);
        push_cmd(arpr_pkg::OP_TICK, 16'h0000, 16'h0000);
        settle();

        // 8-bit mono, top step and volume, hard left pan: catch-up then underrun
        reg_write(arpr_pkg::REG_FORMAT, arpr_pkg::FMT_8_MONO);
        reg_write(arpr_pkg::REG_STEP, 262143);
        reg_write(arpr_pkg::REG_VOLUME, 65535);
        reg_write(arpr_pkg::REG_PAN, -128);
        push_cmd(arpr_pkg::OP_WRITE, 16'hAB80, 16'h1234);
        push_cmd(arpr_pkg::OP_WRITE, 16'h547F, 16'h8000);
        push_cmd(arpr_pkg::OP_WRITE, 16'h00FF, 16'h7F7F);
        push_cmd(arpr_pkg::OP_PLAY, 16'h0000, 16'h0000);
        repeat (2) push_cmd(arpr_pkg::OP_TICK, 16'h0000, 16'h0000);
        settle();

        // zero step gives silence
        reg_write(arpr_pkg::REG_FORMAT, arpr_pkg::FMT_8_STEREO);
        reg_write(arpr_pkg::REG_STEP, 0);
        reg_write(arpr_pkg::REG_VOLUME, 1);
        reg_write(arpr_pkg::REG_PAN, 128);
        push_cmd(arpr_pkg::OP_WRITE, 16'h0081, 16'hFF7E);
        push_cmd(arpr_pkg::OP_TICK, 16'h0000, 16'h0000);
        settle();

        // zero volume gives silence
        reg_write(arpr_pkg::REG_FORMAT, arpr_pkg::FMT_16_MONO);
        reg_write(arpr_pkg::REG_STEP, 98304);
        reg_write(arpr_pkg::REG_VOLUME, 0);
        push_cmd(arpr_pkg::OP_WRITE, 16'h8001, 16'h1111);
        push_cmd(arpr_pkg::OP_TICK, 16'h0000, 16'h0000);
        settle();

        // small odd volume and off-center pan exercise rounding of negatives
        reg_write(arpr_pkg::REG_STEP, 40000);
        reg_write(arpr_pkg::REG_VOLUME, 3);
        reg_write(arpr_pkg::REG_PAN, 37);
        push_cmd(arpr_pkg::OP_WRITE, 16'hFFFB, 16'h0005);
        push_cmd(arpr_pkg::OP_WRITE, 16'h8000, 16'h7FFF);
        repeat (3) push_cmd(arpr_pkg::OP_TICK, 16'h0000, 16'h0000);
        settle();

        for (int ph = 0; ph < 4; ph++)
        begin
            if (ph < 2)
            begin
                send_idle_pct = 49;
                recv_idle_pct = 30;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 0)
            begin
                reg_write(arpr_pkg::REG_FORMAT, arpr_pkg::FMT_16_STEREO);
                reg_write(arpr_pkg::REG_STEP, 1);
                reg_write(arpr_pkg::REG_VOLUME, 65535);
                reg_write(arpr_pkg::REG_PAN, 128);
                add_random(500, 1'b0);
            end
            else if (ph < 3)
            begin
                rand_config();
                add_random(500, 1'b0);
            end
            else
            begin
                rand_config();
                reg_write(arpr_pkg::REG_STEP, 262143);
                // end of stream: drain to underrun, then play again and catch up
                pending = DEPTH - ring_space();
                push_cmd(arpr_pkg::OP_END, 16'h0000, 16'h0000);
                push_cmd(arpr_pkg::OP_PLAY, 16'h0000, 16'h0000);
                repeat (pending / 4 + 4) push_cmd(arpr_pkg::OP_TICK, 16'h0000, 16'h0000);
                push_cmd(arpr_pkg::OP_PLAY, 16'h0000, 16'h0000);
                repeat (2) push_cmd(arpr_pkg::OP_WRITE, 16'($urandom), 16'($urandom));
                repeat (3) push_cmd(arpr_pkg::OP_TICK, 16'h0000, 16'h0000);
                add_random(500, 1'b1);
            end
            settle();
        end

        repeat (8) @(posedge clk);
        if (bad_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
